// File: design/rps_pkg.sv
// rps_pkg: shared types, codes and constants of the permutation shuffle engine
// used by rps_ctrl, rps_datapath and random_permutation_shuffle
`default_nettype none

package rps_pkg;

  // fixed field widths
  localparam int TABLE_W    = 12;
  localparam int OPC_W      = 2;
  localparam int FRAC_W     = 32;
  localparam int RIDX_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int LOGW_W     = 2;
  localparam int BLK_W      = 9;
  localparam int FACTOR_W   = 4;
  localparam int CALC_W     = 13;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOG_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MODE  = 2'd2;

  // configuration reset values
  localparam logic [LOGW_W-1:0] LOGW_RESET  = 2'd1;
  localparam logic [BLK_W-1:0]  BLK_RESET   = 9'd256;
  localparam logic              SHORT_RESET = 1'b0;

  typedef enum logic [OPC_W-1:0] {
    OP_START = 2'd0,
    OP_STEP  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FILL,
    ST_STEP_J,
    ST_STEP_W1,
    ST_STEP_W2,
    ST_READ_WAIT,
    ST_FINISH
  } ctrl_state_e;

  // table read address source
  typedef enum logic [1:0] {
    RD_STEP,
    RD_J,
    RD_IDX
  } rd_sel_e;

  // table write address and data source
  typedef enum logic [1:0] {
    WR_FILL,
    WR_I,
    WR_J
  } wr_sel_e;

  // result register update
  typedef enum logic [1:0] {
    RES_KEEP,
    RES_FLAG,
    RES_OK_ZERO,
    RES_OK_RDATA
  } res_sel_e;

  typedef struct packed {
    logic     load_item;
    logic     start_latch;
    logic     fill_adv;
    logic     mult_load;
    logic     j_load;
    logic     cap_ti;
    logic     step_adv;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     wr_en;
    wr_sel_e  wr_sel;
    res_sel_e res_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    opcode_e opcode;
    logic    len_ok;
    logic    step_ok;
    logic    read_ok;
    logic    fill_last;
  } dp_sts_t;

  // odd factor 2*2^log_width-1, one less in short mode
  function automatic logic [FACTOR_W-1:0] length_factor(input logic [LOGW_W-1:0] lw,
                                                        input logic              sm);
    logic [FACTOR_W-1:0] f;
    case (lw)
      2'd0:    f = 4'd1;
      2'd1:    f = 4'd3;
      2'd2:    f = 4'd7;
      2'd3:    f = 4'd15;
      default: f = 4'd1;
    endcase
    return f - FACTOR_W'(sm);
  endfunction

endpackage

`default_nettype wire

// File: design/rps_ram.sv
// rps_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module rps_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/rps_datapath.sv
// rps_datapath: config registers, length and step state, offset multiplier,
// table memory and result registers; depends on rps_pkg and rps_ram
`default_nettype none

module rps_datapath import rps_pkg::*; #(
  parameter int MAX_ENTRIES = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [OPC_W-1:0]      opcode_i,
  input  wire logic [FRAC_W-1:0]     random_fraction_i,
  input  wire logic [RIDX_W-1:0]     read_index_i,
  input  wire dp_cmd_t               cmd_i,
  output dp_sts_t                    sts_o,
  output logic [TABLE_W-1:0]         entry_value_o,
  output logic                       shuffle_done_o,
  output logic                       status_o
);

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int LEN_W  = IDX_W + 1;
  localparam int PROD_W = LEN_W + FRAC_W;

  // configuration
  logic [LOGW_W-1:0] logw_q;
  logic [BLK_W-1:0]  blk_q;
  logic              short_q;

  // shuffle state
  logic [LEN_W-1:0] length_q;
  logic [IDX_W-1:0] step_q;
  logic             started_q;

  // per-item working registers
  opcode_e           opc_q;
  logic [FRAC_W-1:0] frac_q;
  logic [RIDX_W-1:0] ridx_q;
  logic [LEN_W-1:0]  fill_q;
  logic [PROD_W-1:0] prod_q;
  logic [IDX_W-1:0]  j_q;
  logic [TABLE_W-1:0] ti_q;
  logic [TABLE_W-1:0] res_value_q;
  logic               res_flag_q;

  // table memory signals
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [TABLE_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [TABLE_W-1:0] ram_rdata;

  logic [CALC_W-1:0] len_calc;
  logic              done_w;
  logic [LEN_W-1:0]  span;
  logic [PROD_W-1:0] prod_d;
  logic [LEN_W-1:0]  offset;
  logic [LEN_W-1:0]  jsum;
  logic [LEN_W-1:0]  j_w;

  // length that a start would latch
  assign len_calc = CALC_W'(length_factor(logw_q, short_q)) * CALC_W'(blk_q);

  // done when all length-1 swaps are made
  assign done_w = started_q && ((LEN_W'(step_q) + LEN_W'(1)) >= length_q);

  // offset = floor((length - i) * r / 2^32), then j = i + offset
  assign span   = length_q - LEN_W'(step_q);
  assign prod_d = PROD_W'(span) * PROD_W'(frac_q);
  assign offset = prod_q[PROD_W-1:FRAC_W];
  assign jsum   = LEN_W'(step_q) + offset;
  assign j_w    = (jsum >= length_q) ? (length_q - LEN_W'(1)) : jsum;

  // status toward the controller
  always_comb begin
    sts_o.opcode    = opc_q;
    sts_o.len_ok    = (len_calc >= CALC_W'(2)) &&
                      (32'(len_calc) <= 32'(MAX_ENTRIES));
    sts_o.step_ok   = started_q && !done_w;
    sts_o.read_ok   = started_q && (32'(ridx_q) < 32'(length_q)) &&
                      (32'(ridx_q) < 32'(MAX_ENTRIES));
    sts_o.fill_last = (fill_q == (length_q - LEN_W'(1)));
  end

  // read address select
  always_comb begin
    case (cmd_i.rd_sel)
      RD_STEP: ram_raddr = step_q;
      RD_J:    ram_raddr = j_w[IDX_W-1:0];
      RD_IDX:  ram_raddr = IDX_W'(32'(ridx_q));
      default: ram_raddr = step_q;
    endcase
  end

  // write address and data select
  always_comb begin
    ram_we = cmd_i.wr_en;
    case (cmd_i.wr_sel)
      WR_FILL: begin
        ram_waddr = fill_q[IDX_W-1:0];
        ram_wdata = TABLE_W'(32'(fill_q));
      end
      WR_I: begin
        ram_waddr = step_q;
        ram_wdata = ram_rdata;
      end
      WR_J: begin
        ram_waddr = j_q;
        ram_wdata = ti_q;
      end
      default: begin
        ram_waddr = fill_q[IDX_W-1:0];
        ram_wdata = TABLE_W'(32'(fill_q));
      end
    endcase
  end

  rps_ram #(
    .WIDTH (TABLE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      logw_q  <= LOGW_RESET;
      blk_q   <= BLK_RESET;
      short_q <= SHORT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOG_WIDTH:   logw_q  <= cfg_data_i[LOGW_W-1:0];
        CFG_BLOCK_COUNT: blk_q   <= cfg_data_i[BLK_W-1:0];
        CFG_SHORT_MODE:  short_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // shuffle state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q  <= '0;
      step_q    <= '0;
      started_q <= 1'b0;
    end else if (cmd_i.start_latch) begin
      length_q  <= LEN_W'(32'(len_calc));
      step_q    <= '0;
      started_q <= 1'b1;
    end else if (cmd_i.step_adv) begin
      step_q <= step_q + IDX_W'(1);
    end
  end

  // item, arithmetic and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      opc_q  <= opcode_e'(opcode_i);
      frac_q <= random_fraction_i;
      ridx_q <= read_index_i;
    end
    if (cmd_i.start_latch) begin
      fill_q <= '0;
    end else if (cmd_i.fill_adv) begin
      fill_q <= fill_q + LEN_W'(1);
    end
    if (cmd_i.mult_load) begin
      prod_q <= prod_d;
    end
    if (cmd_i.j_load) begin
      j_q <= j_w[IDX_W-1:0];
    end
    if (cmd_i.cap_ti) begin
      ti_q <= ram_rdata;
    end
    case (cmd_i.res_sel)
      RES_FLAG: begin
        res_value_q <= '0;
        res_flag_q  <= 1'b1;
      end
      RES_OK_ZERO: begin
        res_value_q <= '0;
        res_flag_q  <= 1'b0;
      end
      RES_OK_RDATA: begin
        res_value_q <= ram_rdata;
        res_flag_q  <= 1'b0;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      entry_value_o  <= res_value_q;
      shuffle_done_o <= done_w;
      status_o       <= res_flag_q;
    end
  end

endmodule

`default_nettype wire

// File: design/rps_ctrl.sv
// rps_ctrl: sequencer for start fill, swap, read and output handshake
// depends on rps_pkg
`default_nettype none

module rps_ctrl import rps_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire dp_sts_t sts_i,
  output dp_cmd_t      cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // state and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel  = RD_STEP;
    cmd_o.wr_sel  = WR_FILL;
    cmd_o.res_sel = RES_KEEP;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts_i.opcode)
          OP_START: begin
            if (sts_i.len_ok) begin
              cmd_o.start_latch = 1'b1;
              state_d = ST_FILL;
            end else begin
              cmd_o.res_sel = RES_FLAG;
              state_d = ST_FINISH;
            end
          end
          OP_STEP: begin
            if (sts_i.step_ok) begin
              cmd_o.rd_en     = 1'b1;
              cmd_o.rd_sel    = RD_STEP;
              cmd_o.mult_load = 1'b1;
              state_d = ST_STEP_J;
            end else begin
              cmd_o.res_sel = RES_FLAG;
              state_d = ST_FINISH;
            end
          end
          OP_READ: begin
            if (sts_i.read_ok) begin
              cmd_o.rd_en  = 1'b1;
              cmd_o.rd_sel = RD_IDX;
              state_d = ST_READ_WAIT;
            end else begin
              cmd_o.res_sel = RES_FLAG;
              state_d = ST_FINISH;
            end
          end
          default: begin
            cmd_o.res_sel = RES_FLAG;
            state_d = ST_FINISH;
          end
        endcase
      end
      // identity fill, one entry per cycle
      ST_FILL: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = WR_FILL;
        cmd_o.fill_adv = 1'b1;
        if (sts_i.fill_last) begin
          cmd_o.res_sel = RES_OK_ZERO;
          state_d = ST_FINISH;
        end
      end
      // entry i arrives, fetch entry j
      ST_STEP_J: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_J;
        cmd_o.j_load = 1'b1;
        cmd_o.cap_ti = 1'b1;
        state_d = ST_STEP_W1;
      end
      // entry j arrives, write it to position i
      ST_STEP_W1: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_sel  = WR_I;
        cmd_o.res_sel = RES_OK_RDATA;
        state_d = ST_STEP_W2;
      end
      // old entry i to position j
      ST_STEP_W2: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_sel   = WR_J;
        cmd_o.step_adv = 1'b1;
        state_d = ST_FINISH;
      end
      ST_READ_WAIT: begin
        cmd_o.res_sel = RES_OK_RDATA;
        state_d = ST_FINISH;
      end
      // hand the result to the output register once it is free
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // accepted item is decoded next cycle
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_DECODE)
    else $error("accepted item not decoded");

  // result load always raises output valid
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result load lost");

  // the table is never read and written in one cycle
  a_no_rw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> !cmd_o.rd_en)
    else $error("table read and write collide");

  // swap only runs while a step is still allowed
  a_swap_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP_J || state_q == ST_STEP_W1) |-> sts_i.step_ok)
    else $error("swap past done");

endmodule

`default_nettype wire

// File: design/random_permutation_shuffle.sv
// random_permutation_shuffle: top level of the Fisher-Yates shuffle engine
// depends on rps_pkg, rps_ctrl, rps_datapath (and rps_ram below it)
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/in_ready_o   | opcode_i, random_fraction_i, read_index_i
//  out     | out       | out_valid_o/out_ready_i | entry_value_o, shuffle_done_o, status_o
//
// one item at a time; a flagged item goes from decode to finish, a read waits
// for its table data, a shuffle step makes two reads and two writes on the
// table, and a start fills all L entries, L the table length, one per cycle.
// a new item is taken while the previous result still waits in the output
// register; out stalls hold the sequencer only in its final state.
// reset restores the config defaults and clears length, step and started;
// the table holds garbage until a start fills it. cfg writes are always taken.
`default_nettype none

module random_permutation_shuffle import rps_pkg::*; #(
  parameter int MAX_ENTRIES = 4096
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [OPC_W-1:0]      opcode_i,
  input  wire logic [FRAC_W-1:0]     random_fraction_i,
  input  wire logic [RIDX_W-1:0]     read_index_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [TABLE_W-1:0]         entry_value_o,
  output logic                       shuffle_done_o,
  output logic                       status_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic    cfg_we;

  // config writes are accepted every cycle
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  rps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rps_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .opcode_i          (opcode_i),
    .random_fraction_i (random_fraction_i),
    .read_index_i      (read_index_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .entry_value_o     (entry_value_o),
    .shuffle_done_o    (shuffle_done_o),
    .status_o          (status_o)
  );

endmodule

`default_nettype wire

// File: test/tb_random_permutation_shuffle.sv
// tb_random_permutation_shuffle: self-checking testbench of the shuffle engine, with directed and
// random phases, a built-in predictor, and random idling on both channels
// depends on rps_pkg and random_permutation_shuffle
module tb_random_permutation_shuffle import rps_pkg::*; ();

  localparam int          TABLE_DEPTH = 4096;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          HOLD_CYCLES = 250;
  localparam int          RANDOM_ITEMS = 750;
  localparam int          MAX_REPORTS = 10;
  localparam logic        STATUS_OK   = 1'b0;
  localparam logic        STATUS_FLAG = 1'b1;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct {
    opcode_e            op;
    logic [FRAC_W-1:0]  frac;
    logic [RIDX_W-1:0]  ridx;
  } shuffle_item_t;

  typedef struct {
    logic [TABLE_W-1:0] value;
    logic               done;
    logic               status;
  } shuffle_result_t;

  // clock, reset and dut ports
  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [OPC_W-1:0]      opcode_i = OP_NONE;
  logic [FRAC_W-1:0]     random_fraction_i = '0;
  logic [RIDX_W-1:0]     read_index_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [TABLE_W-1:0]    entry_value_o;
  logic                  shuffle_done_o;
  logic                  status_o;

  // stimulus and scoreboard
  shuffle_item_t   item_fifo[$];
  shuffle_result_t expected_results[$];
  int unsigned     n_queued = 0;
  int unsigned     n_accepted = 0;
  int unsigned     n_results = 0;
  int unsigned     n_failures = 0;
  int unsigned     n_shuffles_done = 0;
  int unsigned     n_starts_ok = 0;
  int unsigned     cycle_count = 0;
  logic            in_fire = 1'b0;
  logic            out_fire = 1'b0;

  // idling control shared with the driver and the receiver
  bit              sender_idle = 1'b1;
  bit              receiver_idle = 1'b1;
  int unsigned     hold_requests = 0;
  int unsigned     hold_served = 0;
  int unsigned     hold_left = 0;
  int unsigned     send_wait = 0;
  int unsigned     recv_wait = 0;

  // predictor state
  logic [TABLE_W-1:0] perm_model [TABLE_DEPTH];
  int unsigned        model_pos = 0;
  int unsigned        model_len = 0;
  bit                 model_started = 1'b0;
  logic [LOGW_W-1:0]  cur_log_width = LOGW_RESET;
  logic [BLK_W-1:0]   cur_block_count = BLK_RESET;
  logic               cur_short_mode = SHORT_RESET;

  random_permutation_shuffle #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .random_fraction_i(random_fraction_i),
    .read_index_i     (read_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .entry_value_o    (entry_value_o),
    .shuffle_done_o   (shuffle_done_o),
    .status_o         (status_o)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // table length for a register setting, zero factor included
  function automatic int unsigned table_length_of(int unsigned lw, int unsigned blocks,
                                                   int unsigned sm);
    return (2 * (1 << lw) - 1 - sm) * blocks;
  endfunction

  function automatic bit table_done();
    return model_started && (model_pos + 1 >= model_len);
  endfunction

  // expected result of one item, updating the predictor state
  function automatic shuffle_result_t predict_shuffle(shuffle_item_t it);
    shuffle_result_t    res;
    int unsigned        len;
    int unsigned        k;
    int unsigned        i;
    int unsigned        j;
    logic [63:0]        prod;
    logic [TABLE_W-1:0] tmp;
    res.value  = '0;
    res.status = STATUS_FLAG;
    case (it.op)
      OP_START: begin
        len = table_length_of(cur_log_width, cur_block_count, cur_short_mode);
        if (len >= 2 && len <= TABLE_DEPTH) begin
          for (k = 0; k < len; k++) perm_model[k] = TABLE_W'(k);
          model_len     = len;
          model_pos     = 0;
          model_started = 1'b1;
          res.status    = STATUS_OK;
          n_starts_ok++;
        end
      end
      OP_STEP: begin
        if (model_started && !table_done()) begin
          i    = model_pos;
          prod = 64'(model_len - i) * 64'(it.frac);
          j    = i + int'(prod >> 32);
          if (j >= model_len) j = model_len - 1;
          tmp           = perm_model[i];
          perm_model[i] = perm_model[j];
          perm_model[j] = tmp;
          res.value     = perm_model[i];
          model_pos     = i + 1;
          res.status    = STATUS_OK;
          if (table_done()) n_shuffles_done++;
        end
      end
      OP_READ: begin
        if (model_started && it.ridx < model_len) begin
          res.value  = perm_model[it.ridx];
          res.status = STATUS_OK;
        end
      end
      default: ;
    endcase
    res.done = table_done();
    return res;
  endfunction

  task automatic note_failure(string msg);
    n_failures++;
    if (n_failures <= MAX_REPORTS) $display("ERROR: %s", msg);
  endtask

  // input driver: one item per handshake, random gap after each while sender_idle is set
  always @(negedge clk_i) begin : driver
    shuffle_item_t cur;
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid_i <= 1'b0;
      end else if (item_fifo.size() > 0) begin
        cur = item_fifo.pop_front();
        in_valid_i        <= 1'b1;
        opcode_i          <= cur.op;
        random_fraction_i <= cur.frac;
        read_index_i      <= cur.ridx;
        send_wait = sender_idle ? $urandom_range(0, 12) : 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver: random stall per item while receiver_idle is set, plus long holds on request
  always @(negedge clk_i) begin : receiver
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      if (out_fire) recv_wait = receiver_idle ? $urandom_range(0, 12) : 0;
      if (recv_wait > 0) begin
        recv_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= rst_ni;
      end
    end
  end

  // monitor: config shadow, prediction on accept, checking on result
  always @(posedge clk_i) begin : monitor
    shuffle_result_t want;
    cycle_count++;
    if (rst_ni) begin
      in_fire  <= in_valid_i && in_ready_o;
      out_fire <= out_valid_o && out_ready_i;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LOG_WIDTH:   cur_log_width   = cfg_data_i[LOGW_W-1:0];
          CFG_BLOCK_COUNT: cur_block_count = cfg_data_i[BLK_W-1:0];
          CFG_SHORT_MODE:  cur_short_mode  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(predict_shuffle('{opcode_e'(opcode_i), random_fraction_i,
                                                     read_index_i}));
        n_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: value %0d done %0b status %0b",
                                 entry_value_o, shuffle_done_o, status_o));
        end else begin
          want = expected_results.pop_front();
          if (entry_value_o !== want.value || shuffle_done_o !== want.done ||
              status_o !== want.status)
            note_failure($sformatf({"result %0d: expected value %0d done %0b status %0b, ",
                                    "got value %0d done %0b status %0b"},
                                   n_results, want.value, want.done, want.status,
                                   entry_value_o, shuffle_done_o, status_o));
        end
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_random_permutation_shuffle failed");
      $finish;
    end
  end

  // stimulus helpers
  task automatic push_item(opcode_e op, logic [FRAC_W-1:0] frac, logic [RIDX_W-1:0] ridx);
    item_fifo.push_back('{op, frac, ridx});
    n_queued++;
  endtask

  function automatic logic [FRAC_W-1:0] draw_fraction();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // noise items: unknown opcode, which is flagged, or a read anywhere in the index range
  task automatic push_noise();
    if ($urandom_range(0, 1) == 0) push_item(OP_NONE, $urandom, RIDX_W'($urandom));
    else                           push_item(OP_READ, $urandom, RIDX_W'($urandom));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // unused data bits carry random values
  task automatic write_config(int unsigned lw, int unsigned blocks, int unsigned sm);
    write_reg(CFG_LOG_WIDTH, {7'($urandom), 2'(lw)});
    write_reg(CFG_BLOCK_COUNT, 9'(blocks));
    write_reg(CFG_SHORT_MODE, {8'($urandom), 1'(sm)});
  endtask

  task automatic wait_idle();
    while (item_fifo.size() != 0 || n_accepted != n_queued || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  // main sequence
  initial begin : stimulus
    int unsigned lw;
    int unsigned blocks;
    int unsigned sm;
    int unsigned len;
    int unsigned rd_limit;
    int unsigned nsteps;
    int unsigned k;
    int unsigned phase;
    int unsigned random_items;
    random_items = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // before any start: everything is flagged
    @(posedge clk_i);
    push_item(OP_STEP, $urandom, '0);
    push_item(OP_READ, '0, '0);
    push_item(OP_NONE, '1, '1);
    wait_idle();

    // two-entry table: range edges, swap at both extremes, step after done, refill
    write_config(0, 2, 0);
    write_reg(CFG_UNUSED, '1);
    @(posedge clk_i);
    push_item(OP_START, '0, '0);
    push_item(OP_READ, '0, 12'd0);
    push_item(OP_READ, '0, 12'd1);
    push_item(OP_READ, '0, 12'd2);
    push_item(OP_READ, '0, '1);
    push_item(OP_STEP, '1, '0);
    push_item(OP_STEP, $urandom, '0);
    push_item(OP_READ, '0, 12'd0);
    push_item(OP_READ, '0, 12'd1);
    push_item(OP_START, '1, '1);
    push_item(OP_STEP, '0, '0);
    push_item(OP_READ, '0, 12'd0);
    wait_idle();

    // bad lengths leave the latched table alone
    write_config(0, 0, 0);
    @(posedge clk_i);
    push_item(OP_START, '0, '0);
    push_item(OP_READ, '0, 12'd1);
    wait_idle();
    write_config(0, 5, 1);
    @(posedge clk_i);
    push_item(OP_START, '0, '0);
    wait_idle();
    write_config(0, 1, 0);
    @(posedge clk_i);
    push_item(OP_START, '0, '0);
    wait_idle();
    write_config(3, 300, 0);
    @(posedge clk_i);
    push_item(OP_START, '0, '0);
    wait_idle();

    // largest table: far swap and the last index
    write_config(3, 273, 0);
    @(posedge clk_i);
    push_item(OP_START, '0, '0);
    push_item(OP_STEP, '1, '0);
    push_item(OP_READ, '0, 12'd0);
    push_item(OP_READ, '0, 12'd4094);
    push_item(OP_READ, '0, 12'd4095);
    wait_idle();

    // random phases: new setting, start, steps with reads, noise, tail
    for (phase = 0; random_items < RANDOM_ITEMS; phase++) begin
      if (phase == 2) begin
        lw = 1;
        blocks = 8;
        sm = 0;
      end else if ($urandom_range(0, 9) == 0) begin
        lw = $urandom_range(0, 3);
        blocks = $urandom_range(0, 511);
        sm = $urandom_range(0, 1);
      end else begin
        lw = $urandom_range(0, 2);
        blocks = $urandom_range(1, 6);
        sm = $urandom_range(0, 1);
      end
      write_config(lw, blocks, sm);
      @(posedge clk_i);
      sender_idle   = ($urandom_range(0, 3) != 0);
      receiver_idle = ($urandom_range(0, 3) != 0);
      // long receiver hold while the sender keeps going
      if (phase == 2) begin
        sender_idle = 1'b0;
        hold_requests++;
      end
      len = table_length_of(lw, blocks, sm);
      rd_limit = (len >= 2 && len <= TABLE_DEPTH) ? len : TABLE_DEPTH;
      nsteps = (len >= 2 && len <= TABLE_DEPTH) ? ((len - 1 < 40) ? len - 1 : 40)
                                                : $urandom_range(1, 4);
      push_item(OP_START, $urandom, RIDX_W'($urandom));
      random_items++;
      for (k = 0; k < nsteps; k++) begin
        push_item(OP_STEP, draw_fraction(), RIDX_W'($urandom));
        random_items++;
        if ($urandom_range(0, 2) == 0) begin
          push_item(OP_READ, $urandom, RIDX_W'($urandom_range(0, rd_limit - 1)));
          random_items++;
        end
        if ($urandom_range(0, 15) == 0) begin
          push_noise();
          random_items++;
        end
        if ($urandom_range(0, 29) == 0) begin
          push_item(OP_START, $urandom, RIDX_W'($urandom));
          random_items++;
        end
      end
      // one more step, usually past done, then a look at the table
      push_item(OP_STEP, draw_fraction(), RIDX_W'($urandom));
      random_items++;
      repeat ($urandom_range(1, 4)) begin
        push_item(OP_READ, $urandom, RIDX_W'($urandom_range(0, rd_limit - 1)));
        random_items++;
      end
      push_noise();
      random_items++;
      wait_idle();
    end

    // drain and let any stray result show up
    wait_idle();
    repeat (40) @(posedge clk_i);
    if (expected_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_results.size()));

    $display("covered %0d items in %0d random phases plus directed cases, %0d results checked",
             n_accepted, phase, n_results);
    $display("%0d good starts, %0d shuffles run to completion, %0d failures",
             n_starts_ok, n_shuffles_done, n_failures);
    if (n_failures == 0) begin
      $display("tb_random_permutation_shuffle passed");
    end else begin
      $display("tb_random_permutation_shuffle failed");
    end
    $finish;
  end

endmodule
